@@ rtl/core/sorted_list_insert_reverse_assert.svh @@
// assertion macros for the sorted list block
`ifndef SORTED_LIST_INSERT_REVERSE_ASSERT_SVH
`define SORTED_LIST_INSERT_REVERSE_ASSERT_SVH

// same-cycle implication, sampled on the block clock
`define SLIR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted list assertion failed");

// next-cycle implication, sampled on the block clock
`define SLIR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted list assertion failed");

`endif

@@ rtl/core/slir_pkg.sv @@
// package with types and constants of the sorted list block
`timescale 1ns / 1ps

package slir_pkg;

  localparam int DefDepth     = 8;
  localparam int DefWordWidth = 32;

  localparam int ValueW = 32;
  localparam int IndexW = 3;
  localparam int PosW   = 4;
  localparam int CountW = 4;
  localparam int ReadN  = 8;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_REVERSE = 2'd1,
    ACT_READ    = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_REV  = 1'b1
  } state_e;

  typedef struct packed {
    action_e                    action;
    logic signed [ValueW-1:0]   value;
    logic        [IndexW-1:0]   index;
  } cmd_t;

  typedef struct packed {
    logic signed [ValueW-1:0]   read_value;
    logic        [PosW-1:0]     position;
    logic        [CountW-1:0]   entry_count;
    status_e                    status;
  } res_t;

  typedef struct packed {
    logic ins;
    logic swap;
    logic phase;
  } cell_ctrl_t;

endpackage

@@ rtl/core/slir_cell.sv @@
// one storage cell of the sorted list chain
`timescale 1ns / 1ps

module slir_cell import slir_pkg::*; #(
  parameter int WORD_WIDTH = DefWordWidth,
  parameter int CW         = 4,
  parameter int IDX        = 0
) (
  input  logic                         clk_i,
  input  cell_ctrl_t                   ctrl_i,
  input  logic        [CW-1:0]         count_i,
  input  logic signed [WORD_WIDTH-1:0] word_i,
  input  logic signed [WORD_WIDTH-1:0] left_i,
  input  logic signed [WORD_WIDTH-1:0] right_i,
  input  logic                         left_lt_i,
  output logic signed [WORD_WIDTH-1:0] entry_o,
  output logic                         lt_o
);

  localparam logic [CW-1:0] MyIdx   = CW'(IDX);
  localparam logic [CW-1:0] NextIdx = CW'(IDX + 1);
  localparam logic          Odd     = 1'(IDX % 2);
  localparam logic          First   = (IDX == 0);

  logic signed [WORD_WIDTH-1:0] entry_q, entry_d;
  logic                         valid;
  logic                         lower;

  assign valid   = MyIdx < count_i;
  assign lt_o    = left_lt_i && valid && (entry_q < word_i);
  assign lower   = (Odd == ctrl_i.phase);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && !lt_o) begin
      entry_d = left_lt_i ? word_i : left_i;
    end else if (ctrl_i.swap) begin
      if (lower && (NextIdx < count_i)) begin
        entry_d = right_i;
      end else if (!lower && valid && !First) begin
        entry_d = left_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ rtl/core/sorted_list_insert_reverse.sv @@
// top level of the sorted insertion list with in-place reverse
`timescale 1ns / 1ps

// Sorted list of up to DEPTH signed words held in a chain of cells, one word
// per cell. A command transfer happens on a clock edge with start high and busy
// low. Insert, read and clear do not raise busy: a new command can follow in
// the next cycle, and the result shows on res_o with done_o high for exactly
// one cycle right after the transfer. Reverse runs as count passes of neighbor
// swaps through the chain (alternating even and odd pairs), so for a list of
// n > 1 entries busy is high while the passes run and the result shows in the
// cycle in which busy falls; on zero or one entry it completes like the other
// commands. The receiver cannot hold results off: each one is present for a
// single cycle and must be captured then. Only the first eight entries are
// reachable by read.
module sorted_list_insert_reverse import slir_pkg::*; #(
  parameter int DEPTH      = DefDepth,
  parameter int WORD_WIDTH = DefWordWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic done_o,
  output res_t res_o
);

`include "sorted_list_insert_reverse_assert.svh"

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int RdN = (DEPTH < ReadN) ? DEPTH : ReadN;
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] round_q, round_d;
  logic          phase_q, phase_d;
  logic          done_q, done_d;
  res_t          res_q, res_d;

  cell_ctrl_t                   ctrl;
  logic                         accept;
  logic                         ins_go;
  logic signed [WORD_WIDTH-1:0] word;
  logic signed [WORD_WIDTH-1:0] entry_w [DEPTH];
  logic        [DEPTH-1:0]      lt_w;
  logic        [DEPTH-1:0]      land_w;
  logic        [CW-1:0]         pos;
  logic signed [WORD_WIDTH-1:0] rd_word;
  logic                         rd_ok;

  assign busy   = (state_q == S_REV);
  assign accept = start && !busy;
  assign ins_go = accept && (cmd_i.action == ACT_INSERT) && (count_q != Full);
  assign word   = WORD_WIDTH'(cmd_i.value);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_WIDTH-1:0] left, right;
    logic                         left_lt;
    if (i == 0) begin : g_first
      assign left    = '0;
      assign left_lt = 1'b1;
    end else begin : g_mid
      assign left    = entry_w[i-1];
      assign left_lt = lt_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = entry_w[i+1];
    end
    assign land_w[i] = left_lt && !lt_w[i];

    slir_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .CW         (CW),
      .IDX        (i)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .count_i   (count_q),
      .word_i    (word),
      .left_i    (left),
      .right_i   (right),
      .left_lt_i (left_lt),
      .entry_o   (entry_w[i]),
      .lt_o      (lt_w[i])
    );
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (land_w[i]) begin
        pos = pos | CW'(i);
      end
    end
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < RdN; i++) begin
      if (cmd_i.index == IndexW'(i)) begin
        rd_word = entry_w[i];
      end
    end
  end

  assign rd_ok = (CW + IndexW)'(cmd_i.index) < (CW + IndexW)'(count_q);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    round_d = round_q;
    phase_d = phase_q;
    done_d  = 1'b0;
    res_d   = res_q;
    ctrl    = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.read_value = '0;
          res_d.position   = '0;
          res_d.status     = STATUS_OK;
          done_d           = 1'b1;
          case (cmd_i.action)
            ACT_INSERT: begin
              if (count_q == Full) begin
                res_d.status = STATUS_FULL;
              end else begin
                ctrl.ins         = 1'b1;
                count_d          = count_q + 1'b1;
                res_d.position   = PosW'(pos);
              end
            end
            ACT_REVERSE: begin
              if (count_q > CW'(1)) begin
                state_d = S_REV;
                round_d = count_q;
                phase_d = 1'b0;
                done_d  = 1'b0;
              end
            end
            ACT_READ: begin
              if (rd_ok) begin
                res_d.read_value = ValueW'(rd_word);
              end else begin
                res_d.status = STATUS_RANGE;
              end
            end
            ACT_CLEAR: begin
              count_d = '0;
            end
            default: begin
              count_d = count_q;
            end
          endcase
          res_d.entry_count = CountW'(count_d);
        end
      end
      S_REV: begin
        ctrl.swap  = 1'b1;
        ctrl.phase = phase_q;
        phase_d    = !phase_q;
        round_d    = round_q - 1'b1;
        if (round_q == CW'(1)) begin
          state_d           = S_IDLE;
          done_d            = 1'b1;
          res_d.entry_count = CountW'(count_q);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      round_q <= '0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      round_q <= round_d;
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `SLIR_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= Full)
  `SLIR_ASSERT_IMPL(a_no_done_in_rev, state_q == S_REV, !done_o)
  `SLIR_ASSERT_NEXT(a_insert_grows, ins_go, done_o && count_q == CW'($past(count_q) + 1'b1))
  `SLIR_ASSERT_NEXT(a_rev_ends, state_q == S_REV && round_q == CW'(1), state_q == S_IDLE && done_o)

endmodule

@@ bench/sorted_list_insert_reverse_test.sv @@
// self-checking testbench for the sorted insertion list with in-place reverse
`timescale 1ns / 1ps

module sorted_list_insert_reverse_test;
  import slir_pkg::*;

  localparam int RandomItems = 400;
  localparam int NoIdleTail  = 80;
  localparam int PressureAt  = 200;
  localparam int DrainCycles = 20;
  localparam int CycleLimit  = 200000;

  class list_scoreboard;
    logic signed [ValueW-1:0] slots[DefDepth];
    int unsigned fill;
    res_t expected_q[$];
    int unsigned errors;
    int unsigned commands;
    int unsigned checked;
    int unsigned full_drops;
    int unsigned range_misses;
    int unsigned long_reverses;

    function new();
      fill = 0;
      errors = 0;
      commands = 0;
      checked = 0;
      full_drops = 0;
      range_misses = 0;
      long_reverses = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function res_t predict(cmd_t c);
      res_t r;
      int i;
      int j;
      int lo;
      int hi;
      logic signed [ValueW-1:0] t;
      r = '0;
      r.status = STATUS_OK;
      case (c.action)
        ACT_INSERT: begin
          if (fill >= DefDepth) begin
            r.status = STATUS_FULL;
            full_drops++;
          end else begin
            i = 0;
            while (i < int'(fill) && $signed(slots[i]) < $signed(c.value)) i++;
            for (j = int'(fill); j > i; j--) slots[j] = slots[j-1];
            slots[i] = c.value;
            fill++;
            r.position = i[PosW-1:0];
          end
        end
        ACT_REVERSE: begin
          if (fill > 1) long_reverses++;
          lo = 0;
          hi = int'(fill) - 1;
          while (lo < hi) begin
            t = slots[hi];
            slots[hi] = slots[lo];
            slots[lo] = t;
            lo++;
            hi--;
          end
        end
        ACT_READ: begin
          if (c.index < fill) begin
            r.read_value = slots[c.index];
          end else begin
            r.status = STATUS_RANGE;
            range_misses++;
          end
        end
        ACT_CLEAR: begin
          fill = 0;
        end
        default: begin
        end
      endcase
      r.entry_count = fill[CountW-1:0];
      return r;
    endfunction

    function void note_cmd(cmd_t c);
      commands++;
      expected_q.push_back(predict(c));
    endfunction

    task check_result(res_t got);
      res_t exp_r;
      if (expected_q.size() == 0) begin
        report("result with no command pending");
      end else begin
        exp_r = expected_q.pop_front();
        checked++;
        if (got.read_value !== exp_r.read_value)
          report($sformatf("read_value %0d, expected %0d", got.read_value,
                           exp_r.read_value));
        if (got.position !== exp_r.position)
          report($sformatf("position %0d, expected %0d", got.position, exp_r.position));
        if (got.entry_count !== exp_r.entry_count)
          report($sformatf("entry_count %0d, expected %0d", got.entry_count,
                           exp_r.entry_count));
        if (got.status !== exp_r.status)
          report($sformatf("status %0d, expected %0d", got.status, exp_r.status));
      end
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd_i = '0;
  logic done_o;
  res_t res_o;
  int unsigned cycles = 0;

  list_scoreboard sb = new();

  sorted_list_insert_reverse DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAIL sorted_list_insert_reverse");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(res_o);
  end

  function automatic cmd_t make_cmd(action_e a, logic signed [ValueW-1:0] v, int idx);
    cmd_t c;
    c.action = a;
    c.value  = v;
    c.index  = idx[IndexW-1:0];
    return c;
  endfunction

  // holds start until a transfer happens, then records it
  task automatic drive_cmd(cmd_t c);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    sb.note_cmd(c);
  endtask

  initial begin
    logic signed [ValueW-1:0] v;
    int pick;
    int idle;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drive_cmd(make_cmd(ACT_READ, 0, 0));
    drive_cmd(make_cmd(ACT_REVERSE, 0, 0));
    drive_cmd(make_cmd(ACT_INSERT, 5, 0));
    drive_cmd(make_cmd(ACT_REVERSE, 0, 0));
    drive_cmd(make_cmd(ACT_READ, 0, 0));
    drive_cmd(make_cmd(ACT_READ, 0, 1));
    drive_cmd(make_cmd(ACT_INSERT, 32'sh7fffffff, 0));
    drive_cmd(make_cmd(ACT_INSERT, 32'sh80000000, 0));
    // equal value lands in front of the existing one
    drive_cmd(make_cmd(ACT_INSERT, 5, 0));
    drive_cmd(make_cmd(ACT_INSERT, -1, 0));
    drive_cmd(make_cmd(ACT_INSERT, 0, 0));
    drive_cmd(make_cmd(ACT_INSERT, 0, 0));
    drive_cmd(make_cmd(ACT_INSERT, 3, 0));
    // list is full now
    drive_cmd(make_cmd(ACT_INSERT, 1, 0));
    drive_cmd(make_cmd(ACT_READ, 0, 7));
    drive_cmd(make_cmd(ACT_REVERSE, 0, 0));
    drive_cmd(make_cmd(ACT_READ, 0, 0));
    drive_cmd(make_cmd(ACT_READ, 0, 7));
    drive_cmd(make_cmd(ACT_CLEAR, 0, 0));
    drive_cmd(make_cmd(ACT_READ, 0, 0));
    drive_cmd(make_cmd(ACT_INSERT, 0, 0));
    drive_cmd(make_cmd(ACT_REVERSE, 0, 0));
    drive_cmd(make_cmd(ACT_READ, 0, 0));

    for (int n = 0; n < RandomItems; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: v = $urandom;
        5, 6, 7: v = int'($urandom_range(0, 8)) - 4;
        8: v = 32'sh7fffffff;
        default: v = 32'sh80000000;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 42) drive_cmd(make_cmd(ACT_INSERT, v, $urandom_range(0, 7)));
      else if (pick < 78) drive_cmd(make_cmd(ACT_READ, v, $urandom_range(0, 7)));
      else if (pick < 92) drive_cmd(make_cmd(ACT_REVERSE, v, $urandom_range(0, 7)));
      else drive_cmd(make_cmd(ACT_CLEAR, v, $urandom_range(0, 7)));

      if (n == PressureAt) begin
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end else if (n < RandomItems - NoIdleTail && $urandom_range(0, 3) == 0) begin
        idle = $urandom_range(1, 19);
        start <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("results still outstanding at end of run");

    $display("covered %0d commands, %0d results checked", sb.commands, sb.checked);
    $display("%0d dropped inserts on a full list, %0d out-of-range reads, %0d reverses",
             sb.full_drops, sb.range_misses, sb.long_reverses);
    if (sb.errors == 0) begin
      $display("PASS sorted_list_insert_reverse");
    end else begin
      $display("FAIL sorted_list_insert_reverse");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/slir_pkg.sv
rtl/core/slir_cell.sv
rtl/core/sorted_list_insert_reverse.sv
bench/sorted_list_insert_reverse_test.sv
